[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert an implication that holds in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert an implication that holds in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ssp_pkg.sv]
// ----------------------------------------------------------------------------
// Servo status packet receiver package
// Shared widths, codes and control types for the receiver modules.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int ST_W    = 3;
    localparam int PCNT_W  = 6;
    localparam int TICK_W  = 24;

    localparam int MAX_PACKET_BYTES_DEF = 64;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 24'd1000;
    localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hFF;

    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_LINE  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_BAD     = 3'd1;
    localparam logic [ST_W-1:0] ST_SUM     = 3'd2;
    localparam logic [ST_W-1:0] ST_TIMEOUT = 3'd3;
    localparam logic [ST_W-1:0] ST_LINE    = 3'd4;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_PARAM  = 1'b1;

    typedef struct packed {
        logic step;
        logic ld_status;
        logic rd_issue;
        logic ld_param;
    } t_dp_cmd;

    typedef struct packed {
        logic is_start;
        logic fin;
        logic ok_more;
        logic param_last;
    } t_dp_stat;

endpackage

[hw/rtl/ssp_ifs.sv]
// ----------------------------------------------------------------------------
// Servo status packet receiver channels
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface ssp_in_if;
    logic                         valid;
    logic                         ready;
    logic [ssp_pkg::CMD_W-1:0]    command;
    logic [ssp_pkg::BYTE_W-1:0]   rx_byte;
    logic [ssp_pkg::BYTE_W-1:0]   target_id;

    modport source (output valid, output command, output rx_byte, output target_id,
                    input ready);
    modport sink (input valid, input command, input rx_byte, input target_id,
                  output ready);
endinterface

interface ssp_out_if;
    logic                         valid;
    logic                         ready;
    logic                         result_kind;
    logic [ssp_pkg::ST_W-1:0]     status;
    logic [ssp_pkg::BYTE_W-1:0]   servo_error;
    logic [ssp_pkg::PCNT_W-1:0]   param_count;
    logic [ssp_pkg::BYTE_W-1:0]   data_byte;
    logic                         last;

    modport source (output valid, output result_kind, output status, output servo_error,
                    output param_count, output data_byte, output last, input ready);
    modport sink (input valid, input result_kind, input status, input servo_error,
                  input param_count, input data_byte, input last, output ready);
endinterface

[hw/rtl/ssp_ctrl.sv]
// ----------------------------------------------------------------------------
// Servo status packet receiver controller
// Sequences reception, status output and the parameter readout run.
// ----------------------------------------------------------------------------
module ssp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  ssp_pkg::t_dp_stat i_stat,
    output ssp_pkg::t_dp_cmd  o_cmd
);
    import ssp_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ARMED = 2'd1;
    localparam logic [1:0] S_PRD   = 2'd2;
    localparam logic [1:0] S_PWAIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_ready;
    logic       accept;
    logic       slot_free;
    logic       step;

    assign in_ready  = ((r_state == S_IDLE) || (r_state == S_ARMED)) && !r_out_valid;
    assign accept    = i_in_valid && in_ready;
    assign slot_free = !r_out_valid || i_out_ready;
    assign step      = accept && (i_stat.is_start || (r_state == S_ARMED));

    assign o_cmd.step      = step;
    assign o_cmd.ld_status = step && i_stat.fin;
    assign o_cmd.rd_issue  = (r_state == S_PRD);
    assign o_cmd.ld_param  = (r_state == S_PWAIT) && slot_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE, S_ARMED: begin
                if (step) begin
                    if (i_stat.is_start) begin
                        n_state = S_ARMED;
                    end else if (i_stat.fin) begin
                        n_state = i_stat.ok_more ? S_PRD : S_IDLE;
                    end
                end
            end
            S_PRD: begin
                n_state = S_PWAIT;
            end
            S_PWAIT: begin
                if (slot_free) begin
                    n_state = i_stat.param_last ? S_IDLE : S_PRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.ld_status || o_cmd.ld_param) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;

endmodule

[hw/rtl/ssp_dp.sv]
// ----------------------------------------------------------------------------
// Servo status packet receiver datapath
// Packet checks, checksum, timeout, parameter memory and result register.
// ----------------------------------------------------------------------------
module ssp_dp #(
    parameter int MAX_PACKET_BYTES = ssp_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ssp_pkg::TICK_W-1:0]  i_cfg_wdata,
    input  logic [ssp_pkg::CMD_W-1:0]   i_command,
    input  logic [ssp_pkg::BYTE_W-1:0]  i_rx_byte,
    input  logic [ssp_pkg::BYTE_W-1:0]  i_target_id,
    input  ssp_pkg::t_dp_cmd            i_cmd,
    output ssp_pkg::t_dp_stat           o_stat,
    output logic                        o_result_kind,
    output logic [ssp_pkg::ST_W-1:0]    o_status,
    output logic [ssp_pkg::BYTE_W-1:0]  o_servo_error,
    output logic [ssp_pkg::PCNT_W-1:0]  o_param_count,
    output logic [ssp_pkg::BYTE_W-1:0]  o_data_byte,
    output logic                        o_last
);
    import ssp_pkg::*;

    localparam int STORE_DEPTH = MAX_PACKET_BYTES - 6;
    localparam int STORE_N     = (STORE_DEPTH > 0) ? STORE_DEPTH : 1;
    localparam int AW          = (STORE_N > 1) ? $clog2(STORE_N) : 1;
    localparam int CNT_W       = $clog2(MAX_PACKET_BYTES);

    logic [TICK_W-1:0] r_timeout;
    logic [BYTE_W-1:0] r_wanted;
    logic [BYTE_W-1:0] n_wanted;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [BYTE_W-1:0] r_first;
    logic [BYTE_W-1:0] n_first;
    logic [BYTE_W-1:0] r_len;
    logic [BYTE_W-1:0] n_len;
    logic [BYTE_W-1:0] r_sum;
    logic [BYTE_W-1:0] n_sum;
    logic [BYTE_W-1:0] r_err;
    logic [BYTE_W-1:0] n_err;
    logic [TICK_W-1:0] r_elapsed;
    logic [TICK_W-1:0] n_elapsed;
    logic [PCNT_W-1:0] r_pcnt;
    logic [AW-1:0]     r_rd_idx;
    logic [BYTE_W-1:0] r_rd_data;
    logic [BYTE_W-1:0] r_mem [STORE_N];

    logic              fin;
    logic [ST_W-1:0]   fin_st;
    logic              fin_ok;
    logic [PCNT_W-1:0] fin_pcnt;
    logic              wr_en;
    logic [CNT_W-1:0]  rel_idx;
    logic [AW-1:0]     wr_addr;

    logic              r_o_kind;
    logic [ST_W-1:0]   r_o_status;
    logic [BYTE_W-1:0] r_o_err;
    logic [PCNT_W-1:0] r_o_pcnt;
    logic [BYTE_W-1:0] r_o_data;
    logic              r_o_last;

    assign rel_idx = r_cnt - CNT_W'(5);
    assign wr_addr = rel_idx[AW-1:0];

    always_comb begin
        n_wanted  = r_wanted;
        n_cnt     = r_cnt;
        n_first   = r_first;
        n_len     = r_len;
        n_sum     = r_sum;
        n_err     = r_err;
        n_elapsed = r_elapsed;
        fin       = 1'b0;
        fin_st    = ST_OK;
        wr_en     = 1'b0;
        unique case (i_command)
            CMD_START: begin
                n_wanted  = i_target_id;
                n_cnt     = '0;
                n_elapsed = '0;
                n_sum     = '0;
                n_len     = '0;
                n_err     = '0;
                n_first   = '0;
            end
            CMD_BYTE: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(0)) begin
                    n_first = i_rx_byte;
                end else if (r_cnt == CNT_W'(1)) begin
                    if ((r_first != HDR_BYTE) || (i_rx_byte != HDR_BYTE)) begin
                        fin    = 1'b1;
                        fin_st = ST_BAD;
                    end
                end else if (r_cnt == CNT_W'(2)) begin
                    if (i_rx_byte != r_wanted) begin
                        fin    = 1'b1;
                        fin_st = ST_BAD;
                    end else begin
                        n_sum = i_rx_byte;
                    end
                end else if (r_cnt == CNT_W'(3)) begin
                    if ((i_rx_byte < 8'd2)
                        || ((9'(i_rx_byte) + 9'd4) > 9'(MAX_PACKET_BYTES))) begin
                        fin    = 1'b1;
                        fin_st = ST_BAD;
                    end else begin
                        n_len = i_rx_byte;
                        n_sum = r_sum + i_rx_byte;
                    end
                end else if (9'(r_cnt) == (9'(r_len) + 9'd3)) begin
                    fin    = 1'b1;
                    fin_st = ((~r_sum) == i_rx_byte) ? ST_OK : ST_SUM;
                end else begin
                    n_sum = r_sum + i_rx_byte;
                    if (r_cnt == CNT_W'(4)) begin
                        n_err = i_rx_byte;
                    end else begin
                        wr_en = (rel_idx < CNT_W'(STORE_DEPTH));
                    end
                end
            end
            CMD_TICK: begin
                n_elapsed = (r_elapsed == '1) ? r_elapsed : (r_elapsed + TICK_W'(1));
                if (n_elapsed > r_timeout) begin
                    fin    = 1'b1;
                    fin_st = ST_TIMEOUT;
                end
            end
            CMD_LINE: begin
                fin    = 1'b1;
                fin_st = ST_LINE;
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    assign fin_ok   = (fin_st == ST_OK);
    assign fin_pcnt = fin_ok ? PCNT_W'(r_len - 8'd2) : '0;

    assign o_stat.is_start   = (i_command == CMD_START);
    assign o_stat.fin        = fin;
    assign o_stat.ok_more    = fin && fin_ok && (fin_pcnt != '0);
    assign o_stat.param_last = (PCNT_W'(r_rd_idx) == (r_pcnt - PCNT_W'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
            r_wanted  <= '0;
            r_cnt     <= '0;
            r_first   <= '0;
            r_len     <= '0;
            r_sum     <= '0;
            r_err     <= '0;
            r_elapsed <= '0;
            r_pcnt    <= '0;
            r_rd_idx  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (i_cmd.step) begin
                r_wanted  <= n_wanted;
                r_cnt     <= n_cnt;
                r_first   <= n_first;
                r_len     <= n_len;
                r_sum     <= n_sum;
                r_err     <= n_err;
                r_elapsed <= n_elapsed;
            end
            if (i_cmd.ld_status) begin
                r_pcnt   <= fin_pcnt;
                r_rd_idx <= '0;
            end else if (i_cmd.ld_param) begin
                r_rd_idx <= r_rd_idx + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && wr_en) begin
            r_mem[wr_addr] <= i_rx_byte;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_status) begin
            r_o_kind   <= KIND_STATUS;
            r_o_status <= fin_st;
            r_o_err    <= fin_ok ? r_err : '0;
            r_o_pcnt   <= fin_pcnt;
            r_o_data   <= '0;
            r_o_last   <= !fin_ok || (fin_pcnt == '0);
        end else if (i_cmd.ld_param) begin
            r_o_kind   <= KIND_PARAM;
            r_o_status <= ST_OK;
            r_o_err    <= '0;
            r_o_pcnt   <= '0;
            r_o_data   <= r_rd_data;
            r_o_last   <= o_stat.param_last;
        end
    end

    assign o_result_kind = r_o_kind;
    assign o_status      = r_o_status;
    assign o_servo_error = r_o_err;
    assign o_param_count = r_o_pcnt;
    assign o_data_byte   = r_o_data;
    assign o_last        = r_o_last;

endmodule

[hw/rtl/servo_status_packet_receiver.sv]
// ----------------------------------------------------------------------------
// Servo status packet receiver
// Result: a status word is offered in the cycle after the word that ends the packet.
// Throughput: words that give no result are taken every cycle; input waits while any
// result word is held or parameter words are read out (registered memory read each).
// Reset: synchronous active low; the block idles and the timeout returns to 1000.
// ----------------------------------------------------------------------------
module servo_status_packet_receiver #(
    parameter int MAX_PACKET_BYTES = ssp_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ssp_pkg::TICK_W-1:0] i_cfg_wdata,
    ssp_in_if.sink                     i_rx,
    ssp_out_if.source                  o_res
);
    import ssp_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ssp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_rx.valid),
        .o_in_ready  (i_rx.ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ssp_dp #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_command     (i_rx.command),
        .i_rx_byte     (i_rx.rx_byte),
        .i_target_id   (i_rx.target_id),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_result_kind (o_res.result_kind),
        .o_status      (o_res.status),
        .o_servo_error (o_res.servo_error),
        .o_param_count (o_res.param_count),
        .o_data_byte   (o_res.data_byte),
        .o_last        (o_res.last)
    );

endmodule

[hw/rtl/ssp_checker.sv]
// ----------------------------------------------------------------------------
// Servo status packet receiver checker
// Port-level assertions on result words, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_res_valid,
    input logic                        i_res_ready,
    input logic                        i_res_kind,
    input logic [ssp_pkg::ST_W-1:0]    i_res_status,
    input logic [ssp_pkg::BYTE_W-1:0]  i_res_error,
    input logic [ssp_pkg::PCNT_W-1:0]  i_res_pcnt,
    input logic [ssp_pkg::BYTE_W-1:0]  i_res_data,
    input logic                        i_res_last
);
    import ssp_pkg::*;

    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_data) && $stable(i_res_kind) && $stable(i_res_last), "Stalled result word changed")
    `ASSERT_SAME(a_param_clean, i_clk, i_rst_n, i_res_valid && i_res_kind, (i_res_status == ST_OK) && (i_res_error == 8'd0) && (i_res_pcnt == '0), "Parameter word carries status fields")
    `ASSERT_SAME(a_fail_last, i_clk, i_rst_n, i_res_valid && !i_res_kind && (i_res_status != ST_OK), i_res_last && (i_res_pcnt == '0) && (i_res_data == 8'd0), "Failed status is not a lone last word")
    `ASSERT_SAME(a_run_blocks, i_clk, i_rst_n, i_res_valid && !i_res_last, !i_in_ready, "Input taken during a result run")

endmodule

bind servo_status_packet_receiver ssp_checker u_ssp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_rx.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_kind   (o_res.result_kind),
    .i_res_status (o_res.status),
    .i_res_error  (o_res.servo_error),
    .i_res_pcnt   (o_res.param_count),
    .i_res_data   (o_res.data_byte),
    .i_res_last   (o_res.last)
);
